@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

@@ design/ptic_pkg.sv @@
// Shared types and constants for the packed triangle index converter.
// Used by ptic_ctrl, ptic_dpath and the top level; no dependencies.
`default_nettype none

package ptic_pkg;

  // Width of the order bits actually used from the matrix_order register
  localparam int unsigned ORDER_BITS = 16;
  localparam int unsigned CRD_W      = 16;
  localparam int unsigned IDX_W      = 31;
  localparam int unsigned OPD_W      = 17;
  localparam int unsigned MUL_W      = 34;
  localparam logic [CRD_W-1:0] ORDER_MASK = CRD_W'((32'd1 << ORDER_BITS) - 32'd1);
  localparam logic [CRD_W-1:0] ORDER_RESET = CRD_W'(1);

  // Operand selection for the shared multiplier
  typedef enum logic [2:0] {
    MulFwd,
    MulTotal,
    MulSquare,
    MulRowCur,
    MulRowNext
  } mul_sel_e;

  // Source of the result transaction
  typedef enum logic [1:0] {
    OutFwd,
    OutRev,
    OutErr
  } out_sel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     root_init;
    logic     root_step;
    logic     est_load;
    logic     r_dec;
    logic     r_inc;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cmd;
    logic fwd_err;
    logic idx_err;
    logic root_last;
    logic rs_gt_k;
    logic r_zero;
    logic r_next_lt_n;
  } dp_status_t;

endpackage

`default_nettype wire

@@ design/ptic_dpath.sv @@
// Datapath of the packed triangle index converter: order register, shared
// multiplier, bit-serial square root, row register and result registers.
// Depends on ptic_pkg.
`default_nettype none

module ptic_dpath
  import ptic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CRD_W-1:0] cfg_data_i,
  input  wire logic             command_i,
  input  wire logic [CRD_W-1:0] row_in_i,
  input  wire logic [CRD_W-1:0] column_in_i,
  input  wire logic [IDX_W-1:0] packed_index_in_i,
  input  wire ctrl_cmd_t        ctl_i,
  output dp_status_t            sts_o,
  output logic      [IDX_W-1:0] packed_index_out_o,
  output logic      [CRD_W-1:0] row_out_o,
  output logic      [CRD_W-1:0] column_out_o,
  output logic                  range_error_o
);

  logic [CRD_W-1:0] order_q;
  logic             cmd_q;
  logic [CRD_W-1:0] row_q, col_q;
  logic [IDX_W-1:0] idx_q;
  logic [MUL_W-1:0] mul_q;
  logic [MUL_W-1:0] rem_q, rem_d;
  logic [MUL_W-1:0] root_q, root_d;
  logic [MUL_W-1:0] bit_q;
  logic [CRD_W-1:0] r_q;
  logic [IDX_W-1:0] pk_q;
  logic [CRD_W-1:0] ro_q, co_q;
  logic             err_q;

  logic [CRD_W-1:0]   n;
  logic [OPD_W-1:0]   n_ext, two_n1, r_ext, r_next;
  logic [OPD_W-1:0]   mul_a, mul_b;
  logic [MUL_W-1:0]   prod;
  logic [MUL_W-2:0]   half;
  logic [MUL_W-2:0]   idx_ext;
  logic [MUL_W-1:0]   trial;
  logic [OPD_W:0]     est_diff;
  logic [OPD_W-1:0]   est;
  logic [CRD_W-1:0]   r_est;
  logic [IDX_W:0]     fwd_sum;
  logic [2*CRD_W-1:0] col_calc;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  assign n       = order_q & ORDER_MASK;
  assign n_ext   = {1'b0, n};
  assign two_n1  = {n, 1'b1};
  assign r_ext   = {1'b0, r_q};
  assign r_next  = r_ext + OPD_W'(1);
  assign half    = mul_q[MUL_W-1:1];
  assign idx_ext = {2'b00, idx_q};

  // Select multiplier operands
  always_comb begin
    mul_a = n_ext;
    mul_b = n_ext + OPD_W'(1);
    case (ctl_i.mul_sel)
      MulFwd: begin
        mul_a = {1'b0, row_q};
        mul_b = two_n1 - {1'b0, row_q} - OPD_W'(2);
      end
      MulTotal: begin
        mul_a = n_ext;
        mul_b = n_ext + OPD_W'(1);
      end
      MulSquare: begin
        mul_a = two_n1;
        mul_b = two_n1;
      end
      MulRowCur: begin
        mul_a = r_ext;
        mul_b = two_n1 - r_ext;
      end
      MulRowNext: begin
        mul_a = r_next;
        mul_b = two_n1 - r_next;
      end
      default: begin
        mul_a = n_ext;
        mul_b = n_ext;
      end
    endcase
  end

  assign prod = {{(MUL_W-OPD_W){1'b0}}, mul_a} * {{(MUL_W-OPD_W){1'b0}}, mul_b};

  // Square root step: trial subtract of root plus current bit
  assign trial = root_q + bit_q;
  always_comb begin
    rem_d  = rem_q;
    root_d = root_q >> 1;
    if (rem_q >= trial) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end
  end

  // Row estimate from the root, clamped to the order
  assign est_diff = {1'b0, two_n1} - root_q[OPD_W:0];
  assign est      = est_diff[OPD_W:1];
  assign r_est    = (est > n_ext) ? n : est[CRD_W-1:0];

  // Input capture, multiplier and root registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= command_i;
      row_q <= row_in_i;
      col_q <= column_in_i;
      idx_q <= packed_index_in_i;
    end
    if (ctl_i.mul_en) begin
      mul_q <= prod;
    end
    if (ctl_i.root_init) begin
      rem_q  <= mul_q - {idx_q, 3'b000};
      root_q <= '0;
      bit_q  <= MUL_W'(1) << (MUL_W - 2);
    end else if (ctl_i.root_step) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      bit_q  <= bit_q >> 2;
    end
    if (ctl_i.est_load) begin
      r_q <= r_est;
    end else if (ctl_i.r_dec) begin
      r_q <= r_q - CRD_W'(1);
    end else if (ctl_i.r_inc) begin
      r_q <= r_q + CRD_W'(1);
    end
  end

  // Result values
  assign fwd_sum  = half[IDX_W:0] + {{(IDX_W+1-CRD_W){1'b0}}, col_q};
  assign col_calc = {1'b0, idx_q} - half[2*CRD_W-1:0] + {{CRD_W{1'b0}}, r_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      case (ctl_i.out_sel)
        OutFwd: begin
          pk_q  <= fwd_sum[IDX_W-1:0];
          ro_q  <= row_q;
          co_q  <= col_q;
          err_q <= 1'b0;
        end
        OutRev: begin
          pk_q  <= idx_q;
          ro_q  <= r_q;
          co_q  <= col_calc[CRD_W-1:0];
          err_q <= 1'b0;
        end
        default: begin
          pk_q  <= '0;
          ro_q  <= '0;
          co_q  <= '0;
          err_q <= 1'b1;
        end
      endcase
    end
  end

  // Status to the controller
  assign sts_o.cmd         = cmd_q;
  assign sts_o.fwd_err     = (row_q > col_q) || (col_q >= n);
  assign sts_o.idx_err     = idx_ext >= half;
  assign sts_o.root_last   = bit_q[0];
  assign sts_o.rs_gt_k     = half > idx_ext;
  assign sts_o.r_zero      = (r_q == '0);
  assign sts_o.r_next_lt_n = r_next < n_ext;

  assign packed_index_out_o = pk_q;
  assign row_out_o          = ro_q;
  assign column_out_o       = co_q;
  assign range_error_o      = err_q;

endmodule

`default_nettype wire

@@ design/ptic_ctrl.sv @@
// Sequencer of the packed triangle index converter: walks the forward or
// reverse conversion steps and owns both channel handshakes. Depends on ptic_pkg.
`default_nettype none

module ptic_ctrl
  import ptic_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       ctl_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FWD_MUL   = 4'd1;
  localparam logic [3:0] S_FWD_WR    = 4'd2;
  localparam logic [3:0] S_TOT_MUL   = 4'd3;
  localparam logic [3:0] S_TOT_CHK   = 4'd4;
  localparam logic [3:0] S_ROOT_INIT = 4'd5;
  localparam logic [3:0] S_ROOT      = 4'd6;
  localparam logic [3:0] S_EST       = 4'd7;
  localparam logic [3:0] S_DN_MUL    = 4'd8;
  localparam logic [3:0] S_DN_CMP    = 4'd9;
  localparam logic [3:0] S_UP_MUL    = 4'd10;
  localparam logic [3:0] S_UP_CMP    = 4'd11;
  localparam logic [3:0] S_COL_MUL   = 4'd12;
  localparam logic [3:0] S_REV_WR    = 4'd13;
  localparam logic [3:0] S_ERR_WR    = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    ctl_o         = '0;
    ctl_o.mul_sel = MulFwd;
    ctl_o.out_sel = OutErr;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          ctl_o.load = 1'b1;
          state_d    = S_FWD_MUL;
        end
      end
      S_FWD_MUL: begin
        if (sts_i.cmd) begin
          state_d = S_TOT_MUL;
        end else begin
          ctl_o.mul_en  = 1'b1;
          ctl_o.mul_sel = MulFwd;
          state_d       = S_FWD_WR;
        end
      end
      S_FWD_WR: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = sts_i.fwd_err ? OutErr : OutFwd;
          state_d        = S_IDLE;
        end
      end
      S_TOT_MUL: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulTotal;
        state_d       = S_TOT_CHK;
      end
      S_TOT_CHK: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulSquare;
        state_d       = sts_i.idx_err ? S_ERR_WR : S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        ctl_o.root_init = 1'b1;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        ctl_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = S_EST;
        end
      end
      S_EST: begin
        ctl_o.est_load = 1'b1;
        state_d        = S_DN_MUL;
      end
      S_DN_MUL: begin
        if (sts_i.r_zero) begin
          state_d = S_UP_MUL;
        end else begin
          ctl_o.mul_en  = 1'b1;
          ctl_o.mul_sel = MulRowCur;
          state_d       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts_i.rs_gt_k) begin
          ctl_o.r_dec = 1'b1;
          state_d     = S_DN_MUL;
        end else begin
          state_d = S_UP_MUL;
        end
      end
      S_UP_MUL: begin
        if (sts_i.r_next_lt_n) begin
          ctl_o.mul_en  = 1'b1;
          ctl_o.mul_sel = MulRowNext;
          state_d       = S_UP_CMP;
        end else begin
          state_d = S_COL_MUL;
        end
      end
      S_UP_CMP: begin
        if (!sts_i.rs_gt_k) begin
          ctl_o.r_inc = 1'b1;
          state_d     = S_UP_MUL;
        end else begin
          state_d = S_COL_MUL;
        end
      end
      S_COL_MUL: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulRowCur;
        state_d       = S_REV_WR;
      end
      S_REV_WR: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = OutRev;
          state_d        = S_IDLE;
        end
      end
      S_ERR_WR: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_sel  = OutErr;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result until the receiver takes the transaction
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/packed_triangle_index_convert_core.sv @@
// Packed upper-triangular index converter, top level.
// Joins the sequencer ptic_ctrl and the datapath ptic_dpath; uses ptic_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one conversion request:
//   command 0 maps (row_in, column_in) to a packed index, command 1 maps
//   packed_index_in back to (row, column). Output channel (out_valid_o /
//   out_stall_i) returns one result transaction per request; range_error
//   flags coordinates or an index outside the triangle, with zeroed fields.
//   matrix_order is written through cfg_we_i / cfg_data_i, by the user only while idle; the block does not enforce it.
// Sequencing:
//   One request is in flight at a time. Command 0 multiplies once and then
//   writes its result. Command 1 multiplies for the total and the square,
//   runs the 17-step bit-serial square root, then corrects the row up or down
//   on the one shared 17x17 multiplier; an index out of range goes straight
//   to the error result.
// Reset: the order returns to 1, the sequencer idles, no result is pending.
// Stall: a finished result stays registered while out_stall_i is high; the
//   next request is still accepted and runs until its own result must be
//   written, where it waits for the output register to free.
`default_nettype none
`include "assert_macros.svh"

module packed_triangle_index_convert_core
  import ptic_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CRD_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             command_i,
  input  wire logic [CRD_W-1:0] row_in_i,
  input  wire logic [CRD_W-1:0] column_in_i,
  input  wire logic [IDX_W-1:0] packed_index_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [IDX_W-1:0] packed_index_out_o,
  output logic      [CRD_W-1:0] row_out_o,
  output logic      [CRD_W-1:0] column_out_o,
  output logic                  range_error_o
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // Sequencer
  ptic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Datapath
  ptic_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .command_i          (command_i),
    .row_in_i           (row_in_i),
    .column_in_i        (column_in_i),
    .packed_index_in_i  (packed_index_in_i),
    .ctl_i              (ctl),
    .sts_o              (sts),
    .packed_index_out_o (packed_index_out_o),
    .row_out_o          (row_out_o),
    .column_out_o       (column_out_o),
    .range_error_o      (range_error_o)
  );

  // An accepted request keeps the input side busy in the next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // Error results carry zeroed fields
  `ASSERT_IMPLIES(a_err_zero, clk_i, rst_ni, out_valid_o && range_error_o, (packed_index_out_o == '0) && (row_out_o == '0) && (column_out_o == '0))

  // A valid coordinate pair never lies below the diagonal
  `ASSERT_IMPLIES(a_upper_tri, clk_i, rst_ni, out_valid_o && !range_error_o, row_out_o <= column_out_o)

endmodule

`default_nettype wire
